// ===== rtl/core/rpmt_pkg.sv =====
package rpmt_pkg;

    // default number of table cells
    localparam int TABLE_DEPTH_DEF = 16;

    // field widths of one item
    localparam int FUNC_W  = 3;
    localparam int ID_W    = 16;
    localparam int KEY_W   = 4 * ID_W;
    localparam int EIDX_W  = 4;
    localparam int MIDX_W  = 4;
    localparam int RCNT_W  = 5;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((KEY_W + EIDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((MIDX_W + KEY_W + RCNT_W + 7) / 8) * 8;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_RM_KEY = 3'd1,
        FN_RM_IDX = 3'd2,
        FN_LOOKUP = 3'd3,
        FN_READ   = 3'd4,
        FN_CLEAR  = 3'd5
    } t_func;

    // per-cell control from the sequencer
    typedef struct packed {
        logic valid;   // cell holds a live entry
        logic cmp;     // capture compare result against the broadcast key
        logic shift;   // take the key of the upper neighbor
        logic load;    // take the broadcast key
    } t_cell_ctrl;

endpackage

// ===== rtl/core/rpmt_cell.sv =====
module rpmt_cell (
    input  logic                           i_clk,
    input  rpmt_pkg::t_cell_ctrl           i_ctrl,
    input  logic [rpmt_pkg::KEY_W-1:0]     i_cmp_key,
    input  logic [rpmt_pkg::KEY_W-1:0]     i_load_key,
    input  logic [rpmt_pkg::KEY_W-1:0]     i_next_key,
    output logic [rpmt_pkg::KEY_W-1:0]     o_key,
    output logic                           o_hit
);

    logic [rpmt_pkg::KEY_W-1:0] r_key;
    logic                       r_hit;

    // stored key: shift down from the neighbor or load a new route
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key <= i_next_key;
        end else if (i_ctrl.load) begin
            r_key <= i_load_key;
        end
    end

    // match flag against the incoming key
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_hit <= i_ctrl.valid && (r_key == i_cmp_key);
        end
    end

    assign o_key = r_key;
    assign o_hit = r_hit;

endmodule

// ===== rtl/core/route_pair_match_table_top.sv =====
// route pair match table: ordered row of key cells with compare and shift-down
// no new item is taken until the last has executed; it executes once the
//   output register is free or being read; cells compare on accept, the
//   execute step priority-encodes the hits and shifts or loads the cells
// a new item is taken while a finished result waits in the output register
// reset (synchronous, active low) empties the table; keys are not cleared
module route_pair_match_table_top #(
    parameter int TABLE_DEPTH = rpmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // src_vid, src_pid, dst_vid, dst_pid, entry_index, zero pad
    input  logic [rpmt_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic [rpmt_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // match_index, out_src_vid, out_src_pid, out_dst_vid, out_dst_pid,
    // route_count, zero pad
    output logic [rpmt_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // ok
    output logic [0:0]                      m_axis_tuser
);

    localparam int KW  = rpmt_pkg::KEY_W;
    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int EW  = rpmt_pkg::EIDX_W;
    localparam int XW  = CW + EW;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [rpmt_pkg::FUNC_W-1:0] r_func;
    logic [KW-1:0]              r_key;
    logic [EW-1:0]              r_idx;
    logic                       r_m_valid;
    logic [rpmt_pkg::M_DATA_W-1:0] r_m_data;
    logic                       r_m_ok;

    logic                       s_fire;
    logic                       x_fire;
    logic [KW-1:0]              in_key;
    logic [KW-1:0]              cell_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     cell_hit;
    rpmt_pkg::t_cell_ctrl       cell_ctrl [TABLE_DEPTH];

    logic                       hit_any;
    logic [IW-1:0]              hit_pos;
    logic                       idx_ok;
    logic [IW-1:0]              idx_pos;
    logic [XW-1:0]              idx_ext;

    logic                       do_shift;
    logic [IW-1:0]              shift_pos;
    logic                       do_load;
    logic                       n_ok;
    logic [IW-1:0]              n_midx;
    logic [KW-1:0]              n_rd;
    logic [rpmt_pkg::M_DATA_W-1:0] n_m_data;

    assign in_key = {s_axis_tdata[15:0], s_axis_tdata[31:16],
                     s_axis_tdata[47:32], s_axis_tdata[63:48]};

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign x_fire        = (r_state == S_EXEC) && (!r_m_valid || m_axis_tready);

    // lowest matching cell
    always_comb begin
        hit_any = 1'b0;
        hit_pos = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (cell_hit[i]) begin
                hit_any = 1'b1;
                hit_pos = IW'(i);
            end
        end
    end

    // entry index against the count
    assign idx_ext = XW'(r_idx);
    assign idx_ok  = idx_ext < XW'(r_count);
    assign idx_pos = idx_ext[IW-1:0];

    // execute step: decide result, shift and load
    always_comb begin
        n_count   = r_count;
        n_ok      = 1'b0;
        n_midx    = '0;
        n_rd      = '0;
        do_shift  = 1'b0;
        shift_pos = '0;
        do_load   = 1'b0;
        case (r_func)
            rpmt_pkg::FN_ADD: begin
                if (hit_any) begin
                    n_midx = hit_pos;
                end else if (r_count < CW'(TABLE_DEPTH)) begin
                    do_load = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            rpmt_pkg::FN_RM_KEY: begin
                if (hit_any) begin
                    n_midx    = hit_pos;
                    do_shift  = 1'b1;
                    shift_pos = hit_pos;
                    n_count   = r_count - CW'(1);
                    n_ok      = 1'b1;
                end
            end
            rpmt_pkg::FN_RM_IDX: begin
                if (idx_ok) begin
                    do_shift  = 1'b1;
                    shift_pos = idx_pos;
                    n_count   = r_count - CW'(1);
                    n_ok      = 1'b1;
                end
            end
            rpmt_pkg::FN_LOOKUP: begin
                if (hit_any) begin
                    n_midx = hit_pos;
                    n_ok   = 1'b1;
                end
            end
            rpmt_pkg::FN_READ: begin
                if (idx_ok) begin
                    n_rd = cell_key[idx_pos];
                    n_ok = 1'b1;
                end
            end
            rpmt_pkg::FN_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result packing
    always_comb begin
        logic [IW+rpmt_pkg::MIDX_W-1:0] midx_ext;
        logic [CW+rpmt_pkg::RCNT_W-1:0] cnt_ext;
        midx_ext = (IW + rpmt_pkg::MIDX_W)'(n_midx);
        cnt_ext  = (CW + rpmt_pkg::RCNT_W)'(n_count);
        n_m_data = '0;
        n_m_data[3:0]   = midx_ext[rpmt_pkg::MIDX_W-1:0];
        n_m_data[19:4]  = n_rd[63:48];
        n_m_data[35:20] = n_rd[47:32];
        n_m_data[51:36] = n_rd[31:16];
        n_m_data[67:52] = n_rd[15:0];
        n_m_data[72:68] = cnt_ext[rpmt_pkg::RCNT_W-1:0];
    end

    // per-cell control
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_ctrl[i].valid = CW'(i) < r_count;
            cell_ctrl[i].cmp   = s_fire;
            cell_ctrl[i].shift = x_fire && do_shift && (IW'(i) >= shift_pos)
                                 && (CW'(i + 1) < r_count);
            cell_ctrl[i].load  = x_fire && do_load && (CW'(i) == r_count);
        end
    end

    // row of cells, each shifting from its upper neighbor
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rpmt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl[g]),
            .i_cmp_key  (in_key),
            .i_load_key (r_key),
            .i_next_key ((g + 1 < TABLE_DEPTH) ? cell_key[(g + 1) % TABLE_DEPTH]
                                               : cell_key[g]),
            .o_key      (cell_key[g]),
            .o_hit      (cell_hit[g])
        );
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_func <= s_axis_tuser;
            r_key  <= in_key;
            r_idx  <= s_axis_tdata[67:64];
        end
    end

    // sequencer, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_state <= S_EXEC;
                    end
                    if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (x_fire) begin
                        r_state   <= S_IDLE;
                        r_count   <= n_count;
                        r_m_valid <= 1'b1;
                        r_m_data  <= n_m_data;
                        r_m_ok    <= n_ok;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_ok;

    // table never holds more entries than cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("route count past table depth");

    // one item at a time: no accept right after an accept
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !s_axis_tready)
        else $error("input accepted during execute");

    // count moves only on an executed item
    a_count_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !x_fire |=> $stable(r_count))
        else $error("route count changed without an item");

endmodule

// ===== dv/route_pair_match_table_top_tb.sv =====
module route_pair_match_table_top_tb;

    localparam int DEPTH = rpmt_pkg::TABLE_DEPTH_DEF;
    localparam int ID_BITS = 4 * rpmt_pkg::ID_W + rpmt_pkg::EIDX_W;

    // codes outside the defined operations
    localparam logic [rpmt_pkg::FUNC_W-1:0] FN_UNDEF_6 = 3'd6;
    localparam logic [rpmt_pkg::FUNC_W-1:0] FN_UNDEF_7 = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    typedef struct packed {
        logic [rpmt_pkg::FUNC_W-1:0] code;
        logic [rpmt_pkg::ID_W-1:0]   src_vid;
        logic [rpmt_pkg::ID_W-1:0]   src_pid;
        logic [rpmt_pkg::ID_W-1:0]   dst_vid;
        logic [rpmt_pkg::ID_W-1:0]   dst_pid;
        logic [rpmt_pkg::EIDX_W-1:0] entry_index;
    } t_route_op;

    typedef struct packed {
        logic                        ok;
        logic [rpmt_pkg::MIDX_W-1:0] match_index;
        logic [rpmt_pkg::ID_W-1:0]   src_vid;
        logic [rpmt_pkg::ID_W-1:0]   src_pid;
        logic [rpmt_pkg::ID_W-1:0]   dst_vid;
        logic [rpmt_pkg::ID_W-1:0]   dst_pid;
        logic [rpmt_pkg::RCNT_W-1:0] route_count;
    } t_route_res;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // src_vid, src_pid, dst_vid, dst_pid, entry_index, zero pad
    logic [rpmt_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    // func
    logic [rpmt_pkg::FUNC_W-1:0]   s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // match_index, out_src_vid, out_src_pid, out_dst_vid, out_dst_pid,
    // route_count, zero pad
    logic [rpmt_pkg::M_DATA_W-1:0] m_axis_tdata;
    // ok
    logic [0:0]                    m_axis_tuser;

    t_route_op  pending_ops[$];
    t_route_res expected_results[$];

    // shadow of the route table
    logic [rpmt_pkg::KEY_W-1:0] route_tbl[DEPTH];
    int               route_cnt = 0;

    int  err_count = 0;
    int  res_count = 0;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    route_pair_match_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // close the gap at pos, later routes move down one place
    task automatic drop_route(input int pos);
        int i;
        for (i = pos; i + 1 < route_cnt; i++) begin
            route_tbl[i] = route_tbl[i + 1];
        end
        route_cnt--;
    endtask

    // apply one operation to the shadow table and form its result
    task automatic predict_route_op(input t_route_op op, output t_route_res res);
        logic [rpmt_pkg::KEY_W-1:0] key;
        int               hit;
        int               i;
        key = {op.src_vid, op.src_pid, op.dst_vid, op.dst_pid};
        res = '0;
        hit = -1;
        for (i = 0; i < route_cnt; i++) begin
            if (hit < 0 && route_tbl[i] == key) hit = i;
        end
        case (op.code)
            rpmt_pkg::FN_ADD: begin
                if (hit >= 0) begin
                    res.match_index = rpmt_pkg::MIDX_W'(hit);
                end else if (route_cnt < DEPTH) begin
                    route_tbl[route_cnt] = key;
                    route_cnt++;
                    res.ok = 1'b1;
                end
            end
            rpmt_pkg::FN_RM_KEY: begin
                if (hit >= 0) begin
                    res.match_index = rpmt_pkg::MIDX_W'(hit);
                    drop_route(hit);
                    res.ok = 1'b1;
                end
            end
            rpmt_pkg::FN_RM_IDX: begin
                if (int'(op.entry_index) < route_cnt) begin
                    drop_route(int'(op.entry_index));
                    res.ok = 1'b1;
                end
            end
            rpmt_pkg::FN_LOOKUP: begin
                if (hit >= 0) begin
                    res.match_index = rpmt_pkg::MIDX_W'(hit);
                    res.ok = 1'b1;
                end
            end
            rpmt_pkg::FN_READ: begin
                if (int'(op.entry_index) < route_cnt) begin
                    {res.src_vid, res.src_pid, res.dst_vid, res.dst_pid} =
                        route_tbl[op.entry_index];
                    res.ok = 1'b1;
                end
            end
            rpmt_pkg::FN_CLEAR: begin
                route_cnt = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.route_count = rpmt_pkg::RCNT_W'(route_cnt);
    endtask

    task automatic queue_op(input logic [rpmt_pkg::FUNC_W-1:0] code,
                            input logic [rpmt_pkg::KEY_W-1:0] key,
                            input logic [rpmt_pkg::EIDX_W-1:0] idx);
        t_route_op op;
        op.code = code;
        {op.src_vid, op.src_pid, op.dst_vid, op.dst_pid} = key;
        op.entry_index = idx;
        pending_ops.push_back(op);
    endtask

    // handshake tracking, result check and prediction
    always @(posedge i_clk) begin
        t_route_res exp_res;
        t_route_res got;
        t_route_res new_res;
        t_route_op  in_op;
        in_taken <= s_axis_tvalid && s_axis_tready;
        out_taken <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            res_count++;
            got.ok          = m_axis_tuser[0];
            got.match_index = m_axis_tdata[3:0];
            got.src_vid     = m_axis_tdata[19:4];
            got.src_pid     = m_axis_tdata[35:20];
            got.dst_vid     = m_axis_tdata[51:36];
            got.dst_pid     = m_axis_tdata[67:52];
            got.route_count = m_axis_tdata[72:68];
            if (expected_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result item: ok=%0d idx=%0d cnt=%0d",
                             got.ok, got.match_index, got.route_count);
            end else begin
                exp_res = expected_results.pop_front();
                if (got.ok !== exp_res.ok || got.match_index !== exp_res.match_index ||
                    got.src_vid !== exp_res.src_vid || got.src_pid !== exp_res.src_pid ||
                    got.dst_vid !== exp_res.dst_vid || got.dst_pid !== exp_res.dst_pid ||
                    got.route_count !== exp_res.route_count) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch expected ok=%0d idx=%0d key=%h_%h_%h_%h cnt=%0d",
                                 exp_res.ok, exp_res.match_index, exp_res.src_vid,
                                 exp_res.src_pid, exp_res.dst_vid, exp_res.dst_pid,
                                 exp_res.route_count);
                        $display("         actual   ok=%0d idx=%0d key=%h_%h_%h_%h cnt=%0d",
                                 got.ok, got.match_index, got.src_vid, got.src_pid,
                                 got.dst_vid, got.dst_pid, got.route_count);
                    end
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            in_op.code        = s_axis_tuser;
            in_op.src_vid     = s_axis_tdata[15:0];
            in_op.src_pid     = s_axis_tdata[31:16];
            in_op.dst_vid     = s_axis_tdata[47:32];
            in_op.dst_pid     = s_axis_tdata[63:48];
            in_op.entry_index = s_axis_tdata[67:64];
            predict_route_op(in_op, new_res);
            expected_results.push_back(new_res);
        end
    end

    // input driver: one item at a time with a random gap after each
    always @(negedge i_clk) begin
        t_route_op op;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else if (!(s_axis_tvalid && !in_taken)) begin
            if (s_axis_tvalid) begin
                if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 19);
            end
            if (tx_wait > 0) begin
                tx_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(rpmt_pkg::S_DATA_W - ID_BITS){1'b0}}, op.entry_index,
                                 op.dst_pid, op.dst_vid, op.src_pid, op.src_vid};
                s_axis_tuser <= op.code;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side: random stall after each item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_taken) begin
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [rpmt_pkg::KEY_W-1:0] key_pool[24];
        logic [rpmt_pkg::KEY_W-1:0] ones_key;
        logic [rpmt_pkg::KEY_W-1:0] fill_key;
        logic [rpmt_pkg::KEY_W-1:0] key;
        logic [rpmt_pkg::FUNC_W-1:0] code;
        logic [rpmt_pkg::EIDX_W-1:0] idx;
        t_mix mix;
        int   r;
        int   add_w, rmk_w, rmi_w, lk_w, rd_w;
        int   total_ops;

        ones_key = '1;
        fill_key = '0;

        // empty table corner cases and undefined codes
        queue_op(rpmt_pkg::FN_CLEAR, '0, '0);
        queue_op(rpmt_pkg::FN_LOOKUP, '0, '0);
        queue_op(rpmt_pkg::FN_READ, '0, '0);
        queue_op(rpmt_pkg::FN_RM_IDX, '0, '0);
        queue_op(rpmt_pkg::FN_RM_KEY, ones_key, '0);
        queue_op(FN_UNDEF_6, ones_key, '1);
        queue_op(FN_UNDEF_7, '0, '0);
        // extreme keys, duplicate add, near miss lookup
        queue_op(rpmt_pkg::FN_ADD, '0, '0);
        queue_op(rpmt_pkg::FN_ADD, ones_key, '0);
        queue_op(rpmt_pkg::FN_ADD, '0, '0);
        queue_op(rpmt_pkg::FN_LOOKUP, ones_key, '0);
        queue_op(rpmt_pkg::FN_LOOKUP, ones_key ^ (64'd1 << 40), '0);
        queue_op(rpmt_pkg::FN_READ, '0, 4'd1);
        queue_op(rpmt_pkg::FN_READ, '0, 4'd15);
        // fill the table, then add to a full table
        for (int i = 1; i <= 14; i++) begin
            fill_key = {$urandom, 28'($urandom), 4'(i)};
            queue_op(rpmt_pkg::FN_ADD, fill_key, '0);
        end
        queue_op(rpmt_pkg::FN_ADD, {$urandom, $urandom}, '0);
        queue_op(rpmt_pkg::FN_READ, '0, 4'd15);
        queue_op(rpmt_pkg::FN_RM_IDX, '0, 4'd15);
        queue_op(rpmt_pkg::FN_RM_KEY, ones_key, '0);
        queue_op(rpmt_pkg::FN_RM_IDX, '0, '0);
        queue_op(rpmt_pkg::FN_LOOKUP, fill_key, '0);
        queue_op(rpmt_pkg::FN_CLEAR, '0, '0);

        // key pool: random keys plus near neighbors that differ in one spot
        for (int p = 0; p < 24; p++) begin
            if (p < 12) begin
                key_pool[p] = {$urandom, $urandom};
            end else if ($urandom_range(0, 1) == 0) begin
                key_pool[p] = key_pool[$urandom_range(0, p - 1)] ^
                              (64'd1 << $urandom_range(0, 63));
            end else begin
                key_pool[p] = key_pool[$urandom_range(0, p - 1)];
                key_pool[p][16 * $urandom_range(0, 3) +: 16] = 16'($urandom);
            end
        end

        // random part in phases that fill, drain or mix the table
        mix = MIX_BALANCED;
        for (int n = 0; n < 1700; n++) begin
            if (n % 60 == 0) mix = t_mix'($urandom_range(0, 2));
            case (mix)
                MIX_FILL:  begin add_w = 55; rmk_w = 8;  rmi_w = 7;  lk_w = 16; rd_w = 13; end
                MIX_DRAIN: begin add_w = 12; rmk_w = 27; rmi_w = 25; lk_w = 17; rd_w = 18; end
                default:   begin add_w = 30; rmk_w = 15; rmi_w = 13; lk_w = 20; rd_w = 20; end
            endcase
            r = $urandom_range(0, 99);
            if (r < add_w) code = rpmt_pkg::FN_ADD;
            else if (r < add_w + rmk_w) code = rpmt_pkg::FN_RM_KEY;
            else if (r < add_w + rmk_w + rmi_w) code = rpmt_pkg::FN_RM_IDX;
            else if (r < add_w + rmk_w + rmi_w + lk_w) code = rpmt_pkg::FN_LOOKUP;
            else if (r < add_w + rmk_w + rmi_w + lk_w + rd_w) code = rpmt_pkg::FN_READ;
            else code = rpmt_pkg::FN_CLEAR;
            if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, 23)];
            else key = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 60) idx = 4'($urandom_range(0, 7));
            else idx = 4'($urandom_range(0, 15));
            queue_op(code, key, idx);
        end
        total_ops = pending_ops.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every queued item has returned its result
        wait (res_count >= total_ops);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rpmt_pkg.sv
rtl/core/rpmt_cell.sv
rtl/core/route_pair_match_table_top.sv
dv/route_pair_match_table_top_tb.sv
